FILE: rtl/core/ssf_pkg.sv
package ssf_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 48;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // shared divider: dividend up to (120000 * 2^31) << 2*FRAC_BITS
    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_Q_W   = 63;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int ROOT_W    = 32;
    localparam int ROOT_IN_W = 64;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [31:0] ATTRACT_GAIN = 32'd120000;
    localparam logic signed [63:0] W_ATTRACT = 64'sd150;
    localparam logic signed [63:0] W_AVOID   = 64'sd200;

    localparam logic [CFG_IDX_W-1:0] REG_AVOID_RADIUS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_RADIUS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_APPROACH_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVOID_ENABLE    = 3'd4;

    localparam logic [CFG_W-1:0] AVOID_RADIUS_RST    = 31'd65536;
    localparam logic [CFG_W-1:0] ALIGN_RADIUS_RST    = 31'd262144;
    localparam logic [CFG_W-1:0] APPROACH_RADIUS_RST = 31'd393216;
    localparam logic [CFG_W-1:0] CRUISE_SPEED_RST    = 31'd3276800;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-2){1'b0}}, 1'b1};
    localparam logic signed [65:0] ACC_MAX_S = $signed({{(66-ACC_W){1'b0}}, ACC_MAX});
    localparam logic signed [65:0] ACC_MIN_S = -ACC_MAX_S;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic signed [COORD_W-1:0] vel_z;
        logic signed [COORD_W-1:0] goal_x;
        logic signed [COORD_W-1:0] goal_y;
        logic signed [COORD_W-1:0] goal_z;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] avoid_radius;
        logic [CFG_W-1:0] align_radius;
        logic [CFG_W-1:0] approach_radius;
        logic [CFG_W-1:0] cruise_speed;
        logic             avoidance_enable;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
        logic               over;
    } div_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [ROOT_IN_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    // a + b clamped to +-ACC_MAX, msb of the result flags the clamp
    function automatic logic [ACC_W:0] sat_acc(input logic signed [ACC_W-1:0] a,
                                               input logic signed [63:0] b);
        logic signed [65:0] s;
        s = $signed({{(66-ACC_W){a[ACC_W-1]}}, a}) + $signed({{2{b[63]}}, b});
        if (s > ACC_MAX_S)
            return {1'b1, ACC_MAX};
        else if (s < ACC_MIN_S)
            return {1'b1, ACC_MIN};
        else
            return {1'b0, s[ACC_W-1:0]};
    endfunction

endpackage

FILE: rtl/core/ssf_front.sv
module ssf_front
    import ssf_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item_in,
    output logic  item_valid,
    output item_t item_out,
    input  logic  item_take
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    item_t         head_reg;
    logic          head_valid_reg;
    logic          do_push, do_pop, do_load;

    assign full       = (count_reg == DEPTH_CNT);
    assign item_valid = head_valid_reg;
    assign item_out   = head_reg;
    assign do_push    = push && !full;
    assign do_pop     = item_take && head_valid_reg;
    // head register holds the oldest transaction, refilled from the array
    assign do_load    = (count_reg != '0) && (!head_valid_reg || do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= item_in;
        if (do_load)
            head_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_load)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_load)
                count_reg <= count_reg + 1'b1;
            else if (do_load && !do_push)
                count_reg <= count_reg - 1'b1;
            if (do_load)
                head_valid_reg <= 1'b1;
            else if (do_pop)
                head_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/ssf_div.sv
module ssf_div
    import ssf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // restoring divider, one quotient bit per cycle
    logic [DIV_NUM_W-1:0] num_reg, quo_reg;
    logic [DIV_DEN_W-1:0] den_reg, rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 over;

    localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_NUM_W - 1);

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
        over    = |quo_reg[DIV_NUM_W-1:DIV_Q_W];
    end

    assign rsp.done     = done_reg;
    assign rsp.over     = over;
    assign rsp.quotient = over ? {DIV_Q_W{1'b1}} : quo_reg[DIV_Q_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                num_reg  <= req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
                rem_reg <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/ssf_sqrt.sv
module ssf_sqrt
    import ssf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    // floor square root, one result bit per cycle
    logic [ROOT_IN_W-1:0] x_reg, r_reg, b_reg;
    logic                 busy_reg, done_reg;
    logic [ROOT_IN_W-1:0] trial;

    assign trial    = r_reg + b_reg;
    assign rsp.done = done_reg;
    assign rsp.root = r_reg[ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            r_reg    <= '0;
            b_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                x_reg    <= req.radicand;
                r_reg    <= '0;
                b_reg    <= {2'b01, {(ROOT_IN_W-2){1'b0}}};
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (x_reg >= trial)
                begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + b_reg;
                end
                else
                    r_reg <= r_reg >> 1;
                b_reg <= b_reg >> 2;
                if (b_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/ssf_back.sv
module ssf_back
    import ssf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_take,
    output logic    res_valid,
    output result_t res,
    input  logic    res_pop
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLASSIFY, S_NB_SQ, S_NB_DIV, S_NB_WAIT, S_NB_ACC, S_POST,
        S_ST_G, S_ST_SQ, S_ST_MUL, S_ST_WAIT, S_ST_ATT, S_ST_F0, S_ST_F1,
        S_SC_MAG, S_SC_NORM, S_SC_SQ, S_SC_ROOT, S_SC_RWAIT, S_SC_MUL, S_SC_DWAIT,
        S_SC_DONE, S_EMIT
    } state_t;

    state_t state_reg;

    logic signed [31:0] own_reg [3];
    logic signed [31:0] goal_reg [3];
    logic signed [31:0] dv_reg [3];
    logic signed [ACC_W-1:0] app_reg [3];
    logic signed [ACC_W-1:0] ali_reg [3];
    logic signed [ACC_W-1:0] avo_reg [3];
    logic               sat_reg;
    item_t              item_reg;
    logic [31:0]        du_reg [3];
    logic               dneg_reg [3];
    logic [63:0]        d2_reg;
    logic               in_ali_reg, in_avo_reg;
    logic [1:0]         idx_reg;
    logic [2:0]         step_reg;
    logic [1:0]         gs_reg;
    logic signed [ACC_W-1:0] att_reg;
    logic signed [63:0] sv_reg [3];
    logic [63:0]        su_reg [3];
    logic               sneg_reg [3];
    logic               to_out_reg;
    logic [ROOT_W-1:0]  n_reg;
    logic signed [31:0] r_reg [3];
    result_t            res_reg;
    logic               res_valid_reg;
    div_req_t           div_req_reg;
    sqrt_req_t          sqrt_req_reg;
    div_rsp_t           div_rsp;
    sqrt_rsp_t          sqrt_rsp;

    logic signed [31:0] pos_v [3];
    logic signed [31:0] vel_v [3];
    logic signed [31:0] goal_v [3];
    logic signed [32:0] nb_diff [3];
    logic [32:0]        nb_mag [3];
    logic               nb_far;
    logic signed [32:0] g_diff [3];
    logic [32:0]        g_mag [3];
    logic [1:0]         g_shift;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    logic signed [63:0] nb_t;
    logic signed [63:0] al_t;
    logic [ACC_W:0]     app_new, ali_new, avo_new;
    logic [63:0]        q2_full;
    logic [ACC_W-1:0]   q2;
    logic               q2_sat;
    logic signed [63:0] f_base;
    logic signed [63:0] f0;
    logic signed [63:0] f1;
    logic               sc_hi, sc_lo, sc_zero;
    logic [31:0]        sc_q;

    ssf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    ssf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req_reg),
        .rsp   (sqrt_rsp)
    );

    assign item_take = (state_reg == S_IDLE) && item_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        pos_v  = '{item_reg.pos_x, item_reg.pos_y, item_reg.pos_z};
        vel_v  = '{item_reg.vel_x, item_reg.vel_y, item_reg.vel_z};
        goal_v = '{item_reg.goal_x, item_reg.goal_y, item_reg.goal_z};
        nb_far = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            nb_diff[i] = {own_reg[i][31], own_reg[i]} - {pos_v[i][31], pos_v[i]};
            nb_mag[i]  = nb_diff[i][32] ? 33'd0 - nb_diff[i] : nb_diff[i];
            if (nb_mag[i] > {2'b00, cfg.approach_radius})
                nb_far = 1'b1;
            g_diff[i] = {goal_reg[i][31], goal_reg[i]} - {own_reg[i][31], own_reg[i]};
            g_mag[i]  = g_diff[i][32] ? 33'd0 - g_diff[i] : g_diff[i];
        end
        if (g_mag[0][32] || g_mag[1][32] || g_mag[2][32])
            g_shift = 2'd2;
        else if (g_mag[0][31] || g_mag[1][31] || g_mag[2][31])
            g_shift = 2'd1;
        else
            g_shift = 2'd0;

        // shared multiplier
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_NB_SQ:
            begin
                case (step_reg)
                    3'd3:    mul_a = {1'b0, cfg.approach_radius};
                    3'd4:    mul_a = {1'b0, cfg.align_radius};
                    3'd5:    mul_a = {1'b0, cfg.avoid_radius};
                    default: mul_a = du_reg[step_reg[1:0]];
                endcase
                mul_b = mul_a;
            end
            S_ST_SQ:
            begin
                mul_a = du_reg[idx_reg];
                mul_b = du_reg[idx_reg];
            end
            S_ST_MUL:
            begin
                mul_a = ATTRACT_GAIN;
                mul_b = du_reg[idx_reg];
            end
            S_SC_SQ:
            begin
                mul_a = {2'b00, su_reg[idx_reg][29:0]};
                mul_b = {2'b00, su_reg[idx_reg][29:0]};
            end
            S_SC_MUL:
            begin
                mul_a = {1'b0, cfg.cruise_speed};
                mul_b = su_reg[idx_reg][31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);

        nb_t = dneg_reg[idx_reg] ? 64'sd0 - $signed({1'b0, div_rsp.quotient})
                                 : $signed({1'b0, div_rsp.quotient});
        al_t = ($signed({{32{dv_reg[idx_reg][31]}}, dv_reg[idx_reg]})
              - $signed({{32{vel_v[idx_reg][31]}}, vel_v[idx_reg]})) <<< 2;
        app_new = sat_acc(app_reg[idx_reg], nb_t);
        ali_new = sat_acc(ali_reg[idx_reg], al_t);
        avo_new = sat_acc(avo_reg[idx_reg], nb_t);

        q2_full = {1'b0, div_rsp.quotient} >> gs_reg;
        q2_sat  = (q2_full > {{(64-ACC_W){1'b0}}, ACC_MAX});
        q2      = q2_sat ? ACC_MAX : q2_full[ACC_W-1:0];

        f_base = $signed({{(64-ACC_W){att_reg[ACC_W-1]}}, att_reg})
               - $signed({{(64-ACC_W){app_reg[idx_reg][ACC_W-1]}}, app_reg[idx_reg]})
               - $signed({{(64-ACC_W){ali_reg[idx_reg][ACC_W-1]}}, ali_reg[idx_reg]});
        f0 = f_base * W_ATTRACT;
        f1 = sv_reg[idx_reg]
           + $signed({{(64-ACC_W){avo_reg[idx_reg][ACC_W-1]}}, avo_reg[idx_reg]}) * W_AVOID;

        sc_hi   = 1'b0;
        sc_lo   = 1'b1;
        sc_zero = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (|su_reg[i][63:30])
                sc_hi = 1'b1;
            if (|su_reg[i][63:29])
                sc_lo = 1'b0;
            if (su_reg[i] != '0)
                sc_zero = 1'b0;
        end
        sc_q = div_rsp.quotient[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            own_reg       <= '{default: '0};
            goal_reg      <= '{default: '0};
            dv_reg        <= '{default: '0};
            app_reg       <= '{default: '0};
            ali_reg       <= '{default: '0};
            avo_reg       <= '{default: '0};
            sat_reg       <= 1'b0;
            item_reg      <= '0;
            du_reg        <= '{default: '0};
            dneg_reg      <= '{default: 1'b0};
            d2_reg        <= '0;
            in_ali_reg    <= 1'b0;
            in_avo_reg    <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
            gs_reg        <= '0;
            att_reg       <= '0;
            sv_reg        <= '{default: '0};
            su_reg        <= '{default: '0};
            sneg_reg      <= '{default: 1'b0};
            to_out_reg    <= 1'b0;
            n_reg         <= '0;
            r_reg         <= '{default: '0};
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
            div_req_reg   <= '0;
            sqrt_req_reg  <= '0;
        end
        else
        begin
            div_req_reg.start  <= 1'b0;
            sqrt_req_reg.start <= 1'b0;
            if (res_pop && res_valid_reg)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg  <= item;
                        state_reg <= S_CLASSIFY;
                    end
                end

                S_CLASSIFY:
                begin
                    if (!item_reg.mode)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            own_reg[i]  <= pos_v[i];
                            goal_reg[i] <= goal_v[i];
                            sv_reg[i]   <= $signed({{32{goal_v[i][31]}}, goal_v[i]})
                                         - $signed({{32{pos_v[i][31]}}, pos_v[i]});
                            app_reg[i]  <= '0;
                            ali_reg[i]  <= '0;
                            avo_reg[i]  <= '0;
                        end
                        sat_reg    <= 1'b0;
                        to_out_reg <= 1'b0;
                        state_reg  <= S_SC_MAG;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            du_reg[i]   <= nb_mag[i][31:0];
                            dneg_reg[i] <= nb_diff[i][32];
                        end
                        d2_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= nb_far ? S_POST : S_NB_SQ;
                    end
                end

                S_NB_SQ:
                begin
                    step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        3'd3:
                        begin
                            if (d2_reg == '0 || d2_reg > prod)
                                state_reg <= S_POST;
                        end
                        3'd4:
                            in_ali_reg <= (d2_reg <= prod);
                        3'd5:
                        begin
                            in_avo_reg <= (d2_reg <= prod);
                            idx_reg    <= '0;
                            state_reg  <= S_NB_DIV;
                        end
                        default:
                            d2_reg <= d2_reg + prod;
                    endcase
                end

                S_NB_DIV:
                begin
                    // 4 * |d| scaled by 2^(2*frac) over d^2
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.dividend <= {14'd0, du_reg[idx_reg], 2'b00,
                                             {(2*FRAC_BITS){1'b0}}};
                    div_req_reg.divisor  <= d2_reg;
                    state_reg            <= S_NB_WAIT;
                end

                S_NB_WAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_NB_ACC;
                end

                S_NB_ACC:
                begin
                    app_reg[idx_reg] <= app_new[ACC_W-1:0];
                    if (in_ali_reg)
                        ali_reg[idx_reg] <= ali_new[ACC_W-1:0];
                    if (in_ali_reg && in_avo_reg)
                        avo_reg[idx_reg] <= avo_new[ACC_W-1:0];
                    if (div_rsp.over || app_new[ACC_W]
                        || (in_ali_reg && ali_new[ACC_W])
                        || (in_ali_reg && in_avo_reg && avo_new[ACC_W]))
                        sat_reg <= 1'b1;
                    if (idx_reg == 2'd2)
                        state_reg <= S_POST;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_NB_DIV;
                    end
                end

                S_POST:
                begin
                    if (!item_reg.last)
                        state_reg <= S_IDLE;
                    else if (cfg.avoidance_enable)
                        state_reg <= S_ST_G;
                    else
                    begin
                        r_reg     <= dv_reg;
                        state_reg <= S_EMIT;
                    end
                end

                S_ST_G:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        du_reg[i]   <= 32'(g_mag[i] >> g_shift);
                        dneg_reg[i] <= g_diff[i][32];
                    end
                    gs_reg    <= g_shift;
                    d2_reg    <= '0;
                    idx_reg   <= '0;
                    state_reg <= S_ST_SQ;
                end

                S_ST_SQ:
                begin
                    d2_reg <= d2_reg + prod;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_ST_MUL;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end

                S_ST_MUL:
                begin
                    if (d2_reg == '0)
                    begin
                        att_reg   <= '0;
                        state_reg <= S_ST_F0;
                    end
                    else
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= {prod[47:0], {(2*FRAC_BITS){1'b0}}};
                        div_req_reg.divisor  <= d2_reg;
                        state_reg            <= S_ST_WAIT;
                    end
                end

                S_ST_WAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_ST_ATT;
                end

                S_ST_ATT:
                begin
                    if (div_rsp.over || q2_sat)
                        sat_reg <= 1'b1;
                    att_reg   <= dneg_reg[idx_reg] ? $signed(ACC_W'(0) - q2) : $signed(q2);
                    state_reg <= S_ST_F0;
                end

                S_ST_F0:
                begin
                    // weighted terms stay far below the 64-bit limit
                    sv_reg[idx_reg] <= f0;
                    state_reg       <= S_ST_F1;
                end

                S_ST_F1:
                begin
                    sv_reg[idx_reg] <= f1;
                    if (idx_reg == 2'd2)
                    begin
                        to_out_reg <= 1'b1;
                        state_reg  <= S_SC_MAG;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_ST_MUL;
                    end
                end

                S_SC_MAG:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        su_reg[i]   <= sv_reg[i][63] ? 64'd0 - sv_reg[i] : sv_reg[i];
                        sneg_reg[i] <= sv_reg[i][63];
                    end
                    state_reg <= S_SC_NORM;
                end

                S_SC_NORM:
                begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (sc_zero)
                    begin
                        r_reg     <= '{default: '0};
                        state_reg <= S_SC_DONE;
                    end
                    else if (sc_hi)
                    begin
                        for (int i = 0; i < 3; i++)
                            su_reg[i] <= su_reg[i] >> 1;
                    end
                    else if (sc_lo)
                    begin
                        for (int i = 0; i < 3; i++)
                            su_reg[i] <= su_reg[i] << 1;
                    end
                    else
                    begin
                        d2_reg    <= '0;
                        idx_reg   <= '0;
                        state_reg <= S_SC_SQ;
                    end
                end

                S_SC_SQ:
                begin
                    d2_reg <= d2_reg + prod;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SC_ROOT;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end

                S_SC_ROOT:
                begin
                    sqrt_req_reg.start    <= 1'b1;
                    sqrt_req_reg.radicand <= d2_reg;
                    state_reg             <= S_SC_RWAIT;
                end

                S_SC_RWAIT:
                begin
                    if (sqrt_rsp.done)
                    begin
                        n_reg     <= sqrt_rsp.root;
                        state_reg <= S_SC_MUL;
                    end
                end

                S_SC_MUL:
                begin
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.dividend <= {{(DIV_NUM_W-64){1'b0}}, prod};
                    div_req_reg.divisor  <= {{(DIV_DEN_W-ROOT_W){1'b0}}, n_reg};
                    state_reg            <= S_SC_DWAIT;
                end

                S_SC_DWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        r_reg[idx_reg] <= sneg_reg[idx_reg] ? $signed(32'd0 - sc_q)
                                                            : $signed(sc_q);
                        if (idx_reg == 2'd2)
                            state_reg <= S_SC_DONE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SC_MUL;
                        end
                    end
                end

                S_SC_DONE:
                begin
                    if (to_out_reg)
                        state_reg <= S_EMIT;
                    else
                    begin
                        dv_reg    <= r_reg;
                        state_reg <= S_POST;
                    end
                end

                S_EMIT:
                begin
                    if (!res_valid_reg)
                    begin
                        res_reg.out_vel_x <= r_reg[0];
                        res_reg.out_vel_y <= r_reg[1];
                        res_reg.out_vel_z <= r_reg[2];
                        res_reg.saturated <= sat_reg;
                        res_valid_reg     <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            app_reg[i] <= '0;
                            ali_reg[i] <= '0;
                            avo_reg[i] <= '0;
                        end
                        sat_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/swarm_steering_force.sv
// a far neighbour is dropped after classification; a neighbour in range takes three
// divisions on the shared divider; an own item is normalized, takes a square root and
// three divisions; a last item with steering adds three more divisions and another
// scaling. the back end takes a new item only once it is idle again.
// a small input queue takes items while the back end works; one result register.
// rst_n resets control state and register defaults asynchronously, not queue data.
module swarm_steering_force
    import ssf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  item_t                item,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    cfg_t    cfg_reg;
    logic    item_valid, item_take;
    item_t   item_q;
    logic    res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avoid_radius     <= AVOID_RADIUS_RST;
            cfg_reg.align_radius     <= ALIGN_RADIUS_RST;
            cfg_reg.approach_radius  <= APPROACH_RADIUS_RST;
            cfg_reg.cruise_speed     <= CRUISE_SPEED_RST;
            cfg_reg.avoidance_enable <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_AVOID_RADIUS:    cfg_reg.avoid_radius     <= wr_data;
                REG_ALIGN_RADIUS:    cfg_reg.align_radius     <= wr_data;
                REG_APPROACH_RADIUS: cfg_reg.approach_radius  <= wr_data;
                REG_CRUISE_SPEED:    cfg_reg.cruise_speed     <= wr_data;
                REG_AVOID_ENABLE:    cfg_reg.avoidance_enable <= wr_data[0];
                default:             ;
            endcase
        end
    end

    ssf_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item_in    (item),
        .item_valid (item_valid),
        .item_out   (item_q),
        .item_take  (item_take)
    );

    ssf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item_q),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (result),
        .res_pop    (pop)
    );

    assign empty = !res_valid;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ssf_pkg::*;

    localparam longint unsigned PAIR_GAIN  = 4;
    localparam longint          W_APPROACH = 150;
    localparam longint          W_ALIGN    = 150;
    localparam longint          INT64_TOP  = 64'sh7fff_ffff_ffff_ffff;
    localparam longint          ACC_TOP    = 64'sh0000_7fff_ffff_ffff;
    localparam int              STALL_LIMIT = 30000;
    localparam int              SETTLE_CYCLES = 2000;

    class steer_scoreboard;
        longint unsigned r_avoid, r_align, r_approach, speed, enable;
        longint own[3], goal[3], want[3];
        longint avoid_acc[3], align_acc[3], appr_acc[3];
        bit sat;
        result_t expected_q[$];
        int mismatches;
        int results_seen;

        function void clear_sums();
            for (int i = 0; i < 3; i++)
            begin
                avoid_acc[i] = 0;
                align_acc[i] = 0;
                appr_acc[i] = 0;
            end
            sat = 0;
        endfunction

        function void reset_state();
            r_avoid = AVOID_RADIUS_RST;
            r_align = ALIGN_RADIUS_RST;
            r_approach = APPROACH_RADIUS_RST;
            speed = CRUISE_SPEED_RST;
            enable = 1;
            for (int i = 0; i < 3; i++)
            begin
                own[i] = 0;
                goal[i] = 0;
                want[i] = 0;
            end
            clear_sums();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_AVOID_RADIUS:    r_avoid = data;
                REG_ALIGN_RADIUS:    r_align = data;
                REG_APPROACH_RADIUS: r_approach = data;
                REG_CRUISE_SPEED:    speed = data;
                REG_AVOID_ENABLE:    enable = data[0];
                default: ;
            endcase
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint clamp_add(longint a, longint b, longint lim);
            logic signed [65:0] s;
            s = a;
            s = s + b;
            if (s > lim)
            begin
                sat = 1;
                return lim;
            end
            if (s < -lim)
            begin
                sat = 1;
                return -lim;
            end
            return longint'(s);
        endfunction

        function longint clamp_mul(longint a, longint c);
            logic signed [79:0] s;
            s = a;
            s = s * c;
            if (s > INT64_TOP)
            begin
                sat = 1;
                return INT64_TOP;
            end
            if (s < -INT64_TOP)
            begin
                sat = 1;
                return -INT64_TOP;
            end
            return longint'(s);
        endfunction

        // floor(a * 2^sh / b), clamped to 2^63-1
        function longint unsigned quot_sat(longint unsigned a, int sh, longint unsigned b);
            logic [127:0] n, q;
            n = {64'd0, a} << sh;
            q = n / {64'd0, b};
            if (q > 128'h7fff_ffff_ffff_ffff)
            begin
                sat = 1;
                return 64'h7fff_ffff_ffff_ffff;
            end
            return q[63:0];
        endfunction

        function longint unsigned floor_root(longint unsigned x);
            longint unsigned r, t;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= x)
                    r = t;
            end
            return r;
        endfunction

        function void unit_scale(input longint v[3], input longint unsigned spd,
                                 output longint r[3]);
            longint unsigned u[3], m, n, q;
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = magnitude(v[i]);
                if (u[i] > m)
                    m = u[i];
            end
            if (m == 0)
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = 0;
                return;
            end
            while (m >= (64'd1 << 30))
            begin
                for (int i = 0; i < 3; i++)
                    u[i] = u[i] >> 1;
                m = m >> 1;
            end
            while (m < (64'd1 << 29))
            begin
                for (int i = 0; i < 3; i++)
                    u[i] = u[i] << 1;
                m = m << 1;
            end
            n = floor_root(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
            for (int i = 0; i < 3; i++)
            begin
                q = spd * u[i] / n;
                r[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        function void add_neighbour(longint p[3], longint vel[3]);
            longint d[3];
            longint unsigned u[3], d2, q;
            longint t;
            d2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = own[i] - p[i];
                u[i] = magnitude(d[i]);
                if (u[i] > r_approach)
                    return;
                d2 += u[i] * u[i];
            end
            if (d2 == 0 || d2 > r_approach * r_approach)
                return;
            for (int i = 0; i < 3; i++)
            begin
                q = quot_sat(PAIR_GAIN * u[i], 2 * FRAC_BITS, d2);
                t = (d[i] < 0) ? -longint'(q) : longint'(q);
                appr_acc[i] = clamp_add(appr_acc[i], t, ACC_TOP);
                if (d2 <= r_align * r_align)
                begin
                    align_acc[i] = clamp_add(align_acc[i],
                                             longint'(PAIR_GAIN) * (want[i] - vel[i]), ACC_TOP);
                    if (d2 <= r_avoid * r_avoid)
                        avoid_acc[i] = clamp_add(avoid_acc[i], t, ACC_TOP);
                end
            end
        endfunction

        function void steering(output longint r[3]);
            longint g[3], att[3], f[3];
            longint unsigned u[3], d2, q;
            int s;
            s = 0;
            d2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                g[i] = goal[i] - own[i];
                u[i] = magnitude(g[i]);
            end
            while ((u[0] >> s) >= (64'd1 << 31) || (u[1] >> s) >= (64'd1 << 31) ||
                   (u[2] >> s) >= (64'd1 << 31))
                s++;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = u[i] >> s;
                d2 += u[i] * u[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                q = 0;
                if (d2 != 0)
                    q = quot_sat(longint'(ATTRACT_GAIN) * u[i], 2 * FRAC_BITS, d2) >> s;
                if (q > ACC_TOP)
                begin
                    sat = 1;
                    q = ACC_TOP;
                end
                att[i] = (g[i] < 0) ? -longint'(q) : longint'(q);
                f[i] = clamp_mul(att[i], W_ATTRACT);
                f[i] = clamp_add(f[i], clamp_mul(-appr_acc[i], W_APPROACH), INT64_TOP);
                f[i] = clamp_add(f[i], clamp_mul(-align_acc[i], W_ALIGN), INT64_TOP);
                f[i] = clamp_add(f[i], clamp_mul(avoid_acc[i], W_AVOID), INT64_TOP);
            end
            unit_scale(f, speed, r);
        endfunction

        function void note_item(item_t it);
            longint p[3], vel[3], d[3], r[3];
            result_t res;
            p[0] = longint'(it.pos_x);
            p[1] = longint'(it.pos_y);
            p[2] = longint'(it.pos_z);
            if (it.mode == 1'b0)
            begin
                goal[0] = longint'(it.goal_x);
                goal[1] = longint'(it.goal_y);
                goal[2] = longint'(it.goal_z);
                for (int i = 0; i < 3; i++)
                begin
                    own[i] = p[i];
                    d[i] = goal[i] - p[i];
                end
                unit_scale(d, speed, want);
                clear_sums();
            end
            else
            begin
                vel[0] = longint'(it.vel_x);
                vel[1] = longint'(it.vel_y);
                vel[2] = longint'(it.vel_z);
                add_neighbour(p, vel);
            end
            if (!it.last)
                return;
            if (enable != 0)
                steering(r);
            else
                for (int i = 0; i < 3; i++)
                    r[i] = want[i];
            res.out_vel_x = r[0][31:0];
            res.out_vel_y = r[1][31:0];
            res.out_vel_z = r[2][31:0];
            res.saturated = sat;
            expected_q.insert(expected_q.size(), res);
            clear_sums();
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.out_vel_x !== exp_r.out_vel_x || got.out_vel_y !== exp_r.out_vel_y ||
                got.out_vel_z !== exp_r.out_vel_z || got.saturated !== exp_r.saturated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch on result %0d: expected vel %0d %0d %0d sat %0b,",
                              " got %0d %0d %0d sat %0b"},
                             results_seen, exp_r.out_vel_x, exp_r.out_vel_y, exp_r.out_vel_z,
                             exp_r.saturated, got.out_vel_x, got.out_vel_y, got.out_vel_z,
                             got.saturated);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    item_t item;
    logic empty;
    logic pop;
    result_t result;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    steer_scoreboard sb;
    int send_idle;
    int recv_idle;
    int items_sent;
    int settings_used;
    int stall_cycles;
    longint cur_own[3];

    swarm_steering_force dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_en)
                sb.write_reg(wr_index, wr_data);
            if (push && !full)
                sb.note_item(item);
            if (pop && !empty)
                sb.check_result(result);
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle);

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic longint rand_off(longint unsigned lim);
        longint unsigned w;
        w = {$urandom, $urandom};
        return longint'(w % (2 * lim + 1)) - longint'(lim);
    endfunction

    function automatic item_t own_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                       logic lst);
        item_t it;
        it.mode = 1'b0;
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        it.vel_x = rand_word();
        it.vel_y = rand_word();
        it.vel_z = rand_word();
        it.goal_x = gx;
        it.goal_y = gy;
        it.goal_z = gz;
        it.last = lst;
        return it;
    endfunction

    function automatic item_t nb_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                      logic lst);
        item_t it;
        it = own_item(px, py, pz, rand_word(), rand_word(), rand_word(), lst);
        it.mode = 1'b1;
        if ($urandom_range(1))
        begin
            it.vel_x = 32'(rand_off(64'd1 << $urandom_range(31)));
            it.vel_y = 32'(rand_off(64'd1 << $urandom_range(31)));
            it.vel_z = 32'(rand_off(64'd1 << $urandom_range(31)));
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        if (it.mode == 1'b0)
        begin
            cur_own[0] = longint'(it.pos_x);
            cur_own[1] = longint'(it.pos_y);
            cur_own[2] = longint'(it.pos_z);
        end
        items_sent++;
        do
            @(posedge clk);
        while (full);
    endtask

    // wait for every expected result, then let the back end settle
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(logic [CFG_W-1:0] avoid, logic [CFG_W-1:0] align,
                            logic [CFG_W-1:0] appr, logic [CFG_W-1:0] spd, logic en);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_AVOID_RADIUS;
        wr_data <= avoid;
        @(negedge clk);
        wr_index <= REG_ALIGN_RADIUS;
        wr_data <= align;
        @(negedge clk);
        wr_index <= REG_APPROACH_RADIUS;
        wr_data <= appr;
        @(negedge clk);
        wr_index <= REG_CRUISE_SPEED;
        wr_data <= spd;
        @(negedge clk);
        wr_index <= REG_AVOID_ENABLE;
        wr_data <= {{(CFG_W-1){1'b0}}, en};
        @(negedge clk);
        wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic random_own(logic lst);
        logic [31:0] p[3], g[3];
        int pick;
        pick = $urandom_range(9);
        for (int i = 0; i < 3; i++)
        begin
            p[i] = (pick < 4) ? rand_word() : 32'(rand_off(64'd1 << 20));
            case ($urandom_range(9))
                0: g[i] = p[i];
                1, 2, 3: g[i] = rand_word();
                default: g[i] = p[i] + 32'(rand_off(64'd1 << $urandom_range(1, 30)));
            endcase
        end
        if (pick == 9)
            g = p;
        send_item(own_item(p[0], p[1], p[2], g[0], g[1], g[2], lst));
    endtask

    task automatic random_neighbour(logic lst);
        longint unsigned lim;
        logic [31:0] p[3];
        case ($urandom_range(5))
            0: lim = sb.r_avoid;
            1: lim = sb.r_align;
            2, 3: lim = sb.r_approach;
            4: lim = 2 * sb.r_approach + 1;
            default: lim = 16;
        endcase
        for (int i = 0; i < 3; i++)
            p[i] = 32'(cur_own[i] - rand_off(lim));
        send_item(nb_item(p[0], p[1], p[2], lst));
    endtask

    task automatic random_steps(int n);
        int stop_at, k;
        item_t it;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
            begin
                k = $urandom_range(5);
                random_own(k == 0);
                for (int j = 1; j <= k; j++)
                    random_neighbour(j == k);
            end
            else
            begin
                it = nb_item(rand_word(), rand_word(), rand_word(), 1'($urandom_range(1)));
                it.mode = 1'($urandom_range(1));
                send_item(it);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        send_idle = 23;
        recv_idle = 78;
        items_sent = 0;
        settings_used = 0;
        stall_cycles = 0;
        cur_own = '{0, 0, 0};
        sb = new();
        sb.reset_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // neighbours before any own item use the reset own position
        send_item(nb_item(32'h8000, 32'h0, 32'h0, 1'b0));
        send_item(nb_item(32'h0, 32'h0, 32'h0, 1'b1));
        // one step touching every radius, a far and an on-radius neighbour
        send_item(own_item(32'h0, 32'h0, 32'h0, 32'h000a_0000, 32'h0, 32'h0, 1'b0));
        send_item(nb_item(32'h8000, 32'h4000, 32'h0, 1'b0));
        send_item(nb_item(32'h0003_0000, 32'h0, 32'h0, 1'b0));
        send_item(nb_item(32'h0, 32'hfffb_0000, 32'h0, 1'b0));
        send_item(nb_item(32'h0064_0000, 32'h0, 32'h0, 1'b0));
        send_item(nb_item(32'h0001_0000, 32'h0, 32'h0, 1'b1));
        // target reached gives a zero force
        send_item(own_item(32'h1234, 32'h5678, 32'h9abc, 32'h1234, 32'h5678, 32'h9abc, 1'b1));
        // widest goal offset, then an extreme neighbour velocity
        send_item(own_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        begin
            item_t it;
            it = nb_item(32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 1'b1);
            it.vel_x = 32'h8000_0000;
            it.vel_y = 32'h7fff_ffff;
            it.vel_z = 32'hffff_ffff;
            send_item(it);
        end
        send_item(own_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h0,
                           32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1'b1));
        // goal one lsb away saturates the attraction
        send_item(own_item(32'h5, 32'h5, 32'h5, 32'h6, 32'h5, 32'h5, 1'b1));
        send_item(own_item(32'h0, 32'h0, 32'h0, 32'hfff0_0000, 32'h0003_0000, 32'h1, 1'b0));
        send_item(nb_item(32'h1, 32'h0, 32'h0, 1'b0));
        send_item(nb_item(32'hffff_ffff, 32'hffff_ffff, 32'h1, 1'b1));
        drain();

        random_steps(230);
        drain();
        set_regs(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 1'b1);
        random_steps(230);
        drain();
        send_idle = 78;
        recv_idle = 23;
        set_regs(31'd0, 31'd0, 31'd0, 31'd0, 1'b0);
        random_steps(120);
        // hold off until the block has handed back everything
        drain();
        random_steps(110);
        drain();
        set_regs(31'h1_0000 + 31'($urandom_range(65535)), 31'h4_0000, 31'h1_0000,
                 31'($urandom_range(1, 32'h7fff_ffff)), 1'b1);
        random_steps(230);
        drain();
        send_idle = 0;
        recv_idle = 0;
        set_regs(31'h0000_8000, 31'h0010_0000, 31'h0040_0000, 31'd1, 1'b1);
        random_steps(120);
        drain();
        set_regs(AVOID_RADIUS_RST, ALIGN_RADIUS_RST, APPROACH_RADIUS_RST, CRUISE_SPEED_RST,
                 1'b0);
        random_steps(110);
        drain();

        $display("run covered %0d input items and %0d results over %0d register settings",
                 items_sent, sb.results_seen, settings_used + 1);
        $display("idle patterns: sender-light, receiver-light and back-to-back; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
